FILE: sv/hers_pkg.sv
// Shared constants, types and byte helpers for the HTML element region stripper.
package hers_pkg;

    localparam int MAX_TAG_LEN = 8;
    localparam int WIN_DEPTH   = MAX_TAG_LEN + 2;
    localparam int MAX_RES     = MAX_TAG_LEN + 1;
    localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_RES + 1);
    localparam int TAG_W       = 64;
    localparam int TLEN_W      = 4;
    localparam int DATA_W      = 16;

    // Configuration register indexes
    localparam logic REG_TAG_CHARS  = 1'b0;
    localparam logic REG_TAG_LENGTH = 1'b1;

    localparam logic [TAG_W-1:0]  TAG_CHARS_RST  = 64'd128025154263411;
    localparam logic [TLEN_W-1:0] TAG_LENGTH_RST = 4'd6;

    // Region modes
    localparam logic [1:0] MODE_OUT   = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_BODY  = 2'd2;
    localparam logic [1:0] MODE_END   = 2'd3;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    typedef logic [7:0] byte_t;

    // One input's worth of results, handed from the scanner to the output buffer
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    empty;
        logic                    done;
        logic                    bal;
    } res_t;

    // ASCII upper case folds to lower case, nothing else changes
    function automatic byte_t fold(input byte_t c);
        byte_t r;
        r = c;
        if (c >= CH_UA && c <= CH_UZ)
            r = c + 8'd32;
        return r;
    endfunction

    // Byte k of the start pattern ("<" + tag) or end pattern ("</" + tag)
    function automatic byte_t pat_at(input int k, input logic endpat,
                                     input logic [TAG_W-1:0] tag);
        int    t;
        byte_t r;
        t = endpat ? k - 2 : k - 1;
        r = 8'h00;
        if (k == 0)
            r = CH_LT;
        else if (endpat && k == 1)
            r = CH_SLASH;
        else if (t >= 0 && t < 8)
            r = tag[8*t +: 8];
        return r;
    endfunction

endpackage

FILE: sv/hers_scan.sv
// Window matcher and region state: judges one input byte per cycle while bytes are accepted.
module hers_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    input  logic [hers_pkg::TAG_W-1:0]    tag_chars,
    input  logic [hers_pkg::TLEN_W-1:0]   tag_length,
    output logic                          load,
    output hers_pkg::res_t                res
);
    import hers_pkg::*;

    logic [1:0]          mode_reg, mode_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    byte_t               win_reg  [WIN_DEPTH];
    byte_t               win_next [WIN_DEPTH];

    byte_t               ext [WIN_DEPTH];
    logic                endpat;
    logic [TLEN_W-1:0]   eff;
    logic [FILL_W-1:0]   plen;
    logic [FILL_W-1:0]   fext;
    logic [FILL_W-1:0]   rem;
    logic [FILL_W-1:0]   shift;
    logic [FILL_W-1:0]   rem_new;
    logic [WIN_DEPTH:0]  ok_vec;
    logic [CNT_W-1:0]    emit_cnt;
    logic                bal;

    // Extended window, prefix tests and pop count
    always_comb
    begin
        endpat = (mode_reg == MODE_BODY);
        eff    = (tag_length > TLEN_W'(MAX_TAG_LEN)) ? TLEN_W'(MAX_TAG_LEN) : tag_length;
        plen   = FILL_W'(eff) + (endpat ? FILL_W'(2) : FILL_W'(1));
        fext   = fill_reg + FILL_W'(1);
        rem    = '0;

        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            if (FILL_W'(j) < fill_reg)
                ext[j] = win_reg[j];
            else if (FILL_W'(j) == fill_reg)
                ext[j] = in_byte;
            else
                ext[j] = 8'h00;
        end

        // ok_vec[i]: dropping i leading bytes leaves a pattern prefix
        for (int i = 0; i <= WIN_DEPTH; i++)
        begin
            rem       = fext - FILL_W'(i);
            ok_vec[i] = (FILL_W'(i) <= fext) && (rem <= plen);
            for (int k = 0; k < WIN_DEPTH - i; k++)
            begin
                if (FILL_W'(k) < rem &&
                    fold(ext[i+k]) != fold(pat_at(k, endpat, tag_chars)))
                    ok_vec[i] = 1'b0;
            end
        end

        // smallest pop count that works
        shift = '0;
        for (int i = WIN_DEPTH; i >= 0; i--)
        begin
            if (ok_vec[i])
                shift = FILL_W'(i);
        end
        rem_new = fext - shift;

        // window after the pops
        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            win_next[j] = 8'h00;
            for (int s = 0; s < WIN_DEPTH - j; s++)
            begin
                if (shift == FILL_W'(s))
                    win_next[j] = ext[j+s];
            end
        end
    end

    // Mode update, flush on the last byte
    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        emit_cnt  = '0;
        case (mode_reg)
            MODE_START, MODE_END:
            begin
                if (in_byte == CH_GT)
                begin
                    mode_next = (mode_reg == MODE_START) ? MODE_BODY : MODE_OUT;
                    fill_next = '0;
                end
            end
            MODE_OUT, MODE_BODY:
            begin
                if (!endpat)
                    emit_cnt = CNT_W'(shift);
                if (rem_new == plen)
                begin
                    mode_next = endpat ? MODE_END : MODE_START;
                    fill_next = '0;
                end
                else
                begin
                    fill_next = rem_new;
                end
            end
            default:
            begin
                mode_next = MODE_OUT;
                fill_next = '0;
            end
        endcase

        bal = (mode_next == MODE_OUT) || (mode_next == MODE_END);
        if (in_last)
        begin
            if (mode_next == MODE_OUT)
                emit_cnt = emit_cnt + CNT_W'(fill_next);
            mode_next = MODE_OUT;
            fill_next = '0;
        end

        for (int m = 0; m < MAX_RES; m++)
            res.bytes[m] = ext[m];
        res.empty = (emit_cnt == '0);
        res.cnt   = (emit_cnt == '0) ? CNT_W'(1) : emit_cnt;
        res.done  = in_last;
        res.bal   = bal;
        load      = accept && (in_last || emit_cnt != '0);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OUT;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
        end
    end

    // Window bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < WIN_DEPTH; j++)
                win_reg[j] <= win_next[j];
        end
    end

endmodule

FILE: sv/hers_out_buf.sv
// Result register: holds one input's results, hands them out one per cycle while tready.
module hers_out_buf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  hers_pkg::res_t               res,
    output logic                         in_ready,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [hers_pkg::DATA_W-1:0]  m_axis_tdata,  // out_byte, stream_done, balanced
    output logic                         m_axis_tuser,  // byte_valid
    output logic                         m_axis_tlast   // run_last
);
    import hers_pkg::*;

    logic [MAX_RES-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    empty_reg;
    logic                    done_reg;
    logic                    bal_reg;
    logic                    xfer;
    logic                    final_beat;

    // Handshake and output fields
    always_comb
    begin
        m_axis_tvalid = (cnt_reg != '0);
        xfer          = m_axis_tvalid && m_axis_tready;
        m_axis_tlast  = (cnt_reg == CNT_W'(1));
        in_ready      = (cnt_reg == '0) || (m_axis_tlast && m_axis_tready);
        final_beat    = m_axis_tlast && done_reg;
        m_axis_tuser  = !empty_reg;
        m_axis_tdata  = {(DATA_W - 10)'(0), bal_reg && final_beat, final_beat,
                         empty_reg ? 8'h00 : bytes_reg[0]};
    end

    // Count of results still to go
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= res.cnt;
        else if (xfer)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // Payload: load a new set or shift to the next byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
            empty_reg <= res.empty;
            done_reg  <= res.done;
            bal_reg   <= res.bal;
        end
        else if (xfer)
        begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

    // A new set only lands on an empty buffer or behind its final transfer
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0 || (cnt_reg == CNT_W'(1) && m_axis_tready)))
        else $error("result set loaded over pending results");

    // Mid-set transfers step the count down by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && cnt_reg > CNT_W'(1)) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("result count did not step");

    // A result without a byte is only the lone end-of-stream marker
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (done_reg && cnt_reg == CNT_W'(1)))
        else $error("empty result outside stream end");

endmodule

FILE: sv/html_element_region_stripper_core.sv
// Top level: config registers, window scanner and result buffer.
// The first result of an input is registered and appears in the cycle after its transfer.
// Throughput, while the receiver is ready: one input per cycle while each input gives
// at most one result; an input giving N results (up to 9) holds the input side until
// its last result transfers. The output side drains one result per cycle from a single
// result register. Reset: region mode outside, window and buffer empty, tag TAG_CHARS_RST/6.
module html_element_region_stripper_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // in_byte
    input  logic                         s_axis_tlast,  // in_last
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [hers_pkg::DATA_W-1:0]  m_axis_tdata,  // out_byte, stream_done, balanced
    output logic                         m_axis_tuser,  // byte_valid
    output logic                         m_axis_tlast,  // run_last
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [hers_pkg::TAG_W-1:0]   cfg_data
);
    import hers_pkg::*;

    logic [TAG_W-1:0]  tag_chars_reg;
    logic [TLEN_W-1:0] tag_length_reg;
    logic              accept;
    logic              load;
    res_t              res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_chars_reg  <= TAG_CHARS_RST;
            tag_length_reg <= TAG_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAG_CHARS:  tag_chars_reg  <= cfg_data;
                REG_TAG_LENGTH: tag_length_reg <= cfg_data[TLEN_W-1:0];
                default:        tag_chars_reg  <= tag_chars_reg;
            endcase
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    hers_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .tag_chars  (tag_chars_reg),
        .tag_length (tag_length_reg),
        .load       (load),
        .res        (res)
    );

    hers_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .res           (res),
        .in_ready      (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/html_element_region_stripper_core_test.sv
// Self-checking testbench for the HTML element region stripper core.
`timescale 1ns / 1ps

module html_element_region_stripper_core_test;

    import hers_pkg::*;

    localparam int RUN_LIMIT    = 300000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 190;
    localparam int MAX_PRINTED  = 40;

    localparam byte_t LC_A     = "a";
    localparam byte_t LC_Z     = "z";
    localparam byte_t CH_SPACE = " ";
    localparam byte_t CH_TILDE = "~";

    // One result of the stripper
    typedef struct packed {
        byte_t data;
        logic  valid;
        logic  rlast;
        logic  done;
        logic  bal;
    } strip_res_t;

    // One directed row: either a tag load or a byte with an optional typed result
    typedef struct packed {
        logic              is_cfg;
        logic [TAG_W-1:0]  chars;
        logic [TLEN_W-1:0] len;
        byte_t             b;
        logic              last;
        logic              typed;
        strip_res_t        want;
    } stim_row_t;

    typedef struct packed {
        byte_t b;
        logic  last;
    } text_item_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                cfg_we;
    logic                cfg_index;
    logic [TAG_W-1:0]    cfg_data;

    // Stripper state as predicted
    logic [TAG_W-1:0]    tag_q;
    logic [TLEN_W-1:0]   tlen_q;
    logic [1:0]          mode_q;
    byte_t               win_q [WIN_DEPTH];
    int                  fill_q;

    strip_res_t          new_res [$];
    strip_res_t          kept_q [$];
    stim_row_t           stim_rows [$];
    text_item_t          stream_q [$];
    byte_t               piece_q [$];

    int                  err_cnt = 0;
    int                  cycles = 0;
    int                  burst_left = 0;
    bit                  hold_req = 1'b0;
    strip_res_t          want_r;

    html_element_region_stripper_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic byte_t lower_ascii(input byte_t c);
        if (c >= CH_UA && c <= CH_UZ)
            return c + 8'd32;
        return c;
    endfunction

    function automatic int eff_len();
        return (tlen_q > MAX_TAG_LEN) ? MAX_TAG_LEN : int'(tlen_q);
    endfunction

    // Byte k of "<" + tag, or of "</" + tag when closing
    function automatic byte_t pattern_byte(input int k, input bit closing);
        int t;
        if (k == 0)
            return CH_LT;
        if (closing && k == 1)
            return CH_SLASH;
        t = closing ? k - 2 : k - 1;
        if (t >= 8)
            return 8'h00;
        return tag_q[8*t +: 8];
    endfunction

    function automatic bit window_fits(input int plen, input bit closing);
        int k;
        if (fill_q > plen)
            return 1'b0;
        for (k = 0; k < fill_q; k++)
            if (lower_ascii(win_q[k]) != lower_ascii(pattern_byte(k, closing)))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic byte_t pop_window();
        byte_t v;
        int    k;
        v = win_q[0];
        for (k = 0; k + 1 < fill_q; k++)
            win_q[k] = win_q[k+1];
        fill_q--;
        return v;
    endfunction

    function automatic strip_res_t mk_res(input byte_t d, input logic valid,
                                          input logic rlast, input logic done,
                                          input logic bal);
        strip_res_t r;
        r.data  = d;
        r.valid = valid;
        r.rlast = rlast;
        r.done  = done;
        r.bal   = bal;
        return r;
    endfunction

    function automatic void keep_byte(input byte_t v);
        if (new_res.size() < MAX_RES)
            new_res.push_back(mk_res(v, 1'b1, 1'b0, 1'b0, 1'b0));
    endfunction

    // Results caused by one input byte, left in new_res
    function automatic void predict_item(input byte_t b, input bit last);
        bit         closing;
        bit         bal;
        int         plen;
        int         k;
        byte_t      v;
        strip_res_t r;
        new_res.delete();
        if (mode_q == MODE_START || mode_q == MODE_END)
        begin
            // inside a tag: only '>' matters
            if (b == CH_GT)
            begin
                mode_q = (mode_q == MODE_START) ? MODE_BODY : MODE_OUT;
                fill_q = 0;
            end
        end
        else
        begin
            closing = (mode_q == MODE_BODY);
            plen    = eff_len() + (closing ? 2 : 1);
            if (fill_q >= WIN_DEPTH)
            begin
                v = pop_window();
                if (!closing)
                    keep_byte(v);
            end
            win_q[fill_q] = b;
            fill_q++;
            while (!window_fits(plen, closing))
            begin
                v = pop_window();
                if (!closing)
                    keep_byte(v);
            end
            if (fill_q == plen)
            begin
                mode_q = closing ? MODE_END : MODE_START;
                fill_q = 0;
            end
        end
        // end of stream: flush and report
        if (last)
        begin
            bal = (mode_q == MODE_OUT || mode_q == MODE_END);
            if (mode_q == MODE_OUT)
                for (k = 0; k < fill_q; k++)
                    keep_byte(win_q[k]);
            if (new_res.size() == 0)
                new_res.push_back('0);
            r      = new_res.pop_back();
            r.done = 1'b1;
            r.bal  = bal;
            new_res.push_back(r);
            mode_q = MODE_OUT;
            fill_q = 0;
        end
        if (new_res.size() > 0)
        begin
            r       = new_res.pop_back();
            r.rlast = 1'b1;
            new_res.push_back(r);
        end
    endfunction

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        if (err_cnt < MAX_PRINTED)
            $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, exp_v);
        err_cnt++;
    endtask

    // Sampled mid-cycle so the transfer at the next edge is already settled
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (kept_q.size() == 0)
                report_mismatch("result with nothing expected, out_byte",
                                m_axis_tdata[7:0], 0);
            else
            begin
                want_r = kept_q.pop_front();
                if (m_axis_tdata[7:0] !== want_r.data)
                    report_mismatch("out_byte", m_axis_tdata[7:0], want_r.data);
                if (m_axis_tuser !== want_r.valid)
                    report_mismatch("byte_valid", m_axis_tuser, want_r.valid);
                if (m_axis_tlast !== want_r.rlast)
                    report_mismatch("run_last", m_axis_tlast, want_r.rlast);
                if (m_axis_tdata[8] !== want_r.done)
                    report_mismatch("stream_done", m_axis_tdata[8], want_r.done);
                if (m_axis_tdata[9] !== want_r.bal)
                    report_mismatch("balanced", m_axis_tdata[9], want_r.bal);
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver: random ready pattern, plus one long hold-off on request
    //------------------------------------------------------------------

    initial
    begin
        int run_left;
        int stall_left;
        bit hold_done;
        run_left      = 0;
        stall_left    = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 10);
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Sender side
    //------------------------------------------------------------------

    // Offer one byte in bursts; record its results once the transfer is certain
    task automatic send_item(input byte_t b, input bit last, input bit typed,
                             input strip_res_t want);
        int k;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(negedge clk);
        while (!s_axis_tready);
        predict_item(b, last);
        if (typed)
            kept_q.push_back(want);
        else
            for (k = 0; k < new_res.size(); k++)
                kept_q.push_back(new_res[k]);
        @(posedge clk);
    endtask

    // Stop offering and let all results drain before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (kept_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both tag registers on consecutive edges
    task automatic load_tag(input logic [TAG_W-1:0] chars, input logic [TLEN_W-1:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TAG_CHARS;
        cfg_data  <= chars;
        @(posedge clk);
        cfg_index <= REG_TAG_LENGTH;
        cfg_data  <= {{(TAG_W-TLEN_W){1'b0}}, len};
        @(posedge clk);
        cfg_we <= 1'b0;
        tag_q  = chars;
        tlen_q = len;
    endtask

    //------------------------------------------------------------------
    // Directed table
    //------------------------------------------------------------------

    task automatic add_cfg(input logic [TAG_W-1:0] chars, input logic [TLEN_W-1:0] len);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.chars  = chars;
        r.len    = len;
        stim_rows.push_back(r);
    endtask

    task automatic add_byte(input byte_t b, input bit last, input bit typed,
                            input strip_res_t want);
        stim_row_t r;
        r       = '0;
        r.b     = b;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        stim_rows.push_back(r);
    endtask

    task automatic add_text(input string s, input bit last_at_end);
        int k;
        for (k = 0; k < s.len(); k++)
            add_byte(s[k], last_at_end && (k == s.len() - 1), 1'b0, '0);
    endtask

    //------------------------------------------------------------------
    // Random streams
    //------------------------------------------------------------------

    function automatic byte_t flip_case(input byte_t c);
        bit letter;
        letter = (c >= CH_UA && c <= CH_UZ) || (c >= LC_A && c <= LC_Z);
        if (letter && $urandom_range(0, 1) == 1)
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic byte_t text_byte();
        return byte_t'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    function automatic byte_t letter_byte();
        return $urandom_range(0, 1) ? byte_t'($urandom_range(LC_A, LC_Z))
                                    : byte_t'($urandom_range(CH_UA, CH_UZ));
    endfunction

    task automatic push_name();
        int k;
        for (k = 0; k < eff_len(); k++)
            piece_q.push_back(flip_case(tag_q[8*k +: 8]));
    endtask

    // Mostly well-formed elements with random content, some text and noise
    task automatic build_stream(input int want_len, input bit end_stream);
        int         kind;
        int         n;
        int         cut;
        int         k;
        byte_t      c;
        text_item_t it;
        stream_q.delete();
        while (stream_q.size() < want_len)
        begin
            piece_q.delete();
            kind = $urandom_range(0, 19);
            if (kind < 11)
            begin
                piece_q.push_back(CH_LT);
                push_name();
                n = $urandom_range(0, 3);
                for (k = 0; k < n; k++)
                begin
                    c = text_byte();
                    piece_q.push_back((c == CH_GT) ? CH_SPACE : c);
                end
                piece_q.push_back(CH_GT);
                n = $urandom_range(0, 8);
                for (k = 0; k < n; k++)
                    piece_q.push_back(text_byte());
                piece_q.push_back(CH_LT);
                piece_q.push_back(CH_SLASH);
                push_name();
                if ($urandom_range(0, 2) == 0)
                    piece_q.push_back(CH_SPACE);
                piece_q.push_back(CH_GT);
                // broken element: cut off somewhere
                if ($urandom_range(0, 5) == 0)
                begin
                    cut = $urandom_range(1, piece_q.size() - 1);
                    while (piece_q.size() > cut)
                        c = piece_q.pop_back();
                end
            end
            else if (kind < 17)
            begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    piece_q.push_back(text_byte());
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (k = 0; k < n; k++)
                    piece_q.push_back(byte_t'($urandom_range(0, 255)));
            end
            for (k = 0; k < piece_q.size(); k++)
            begin
                it.b    = piece_q[k];
                it.last = 1'b0;
                stream_q.push_back(it);
            end
        end
        it      = stream_q.pop_back();
        it.last = end_stream;
        stream_q.push_back(it);
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial
    begin
        int               i;
        int               k;
        int               phase;
        int               rand_cnt;
        int               sel;
        logic [TAG_W-1:0] chars;
        logic [TLEN_W-1:0] len;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_TAG_CHARS;
        cfg_data      = '0;
        tag_q         = TAG_CHARS_RST;
        tlen_q        = TAG_LENGTH_RST;
        mode_q        = MODE_OUT;
        fill_q        = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte streams under the reset tag
        add_byte("x",   1'b1, 1'b1, mk_res("x",   1'b1, 1'b1, 1'b1, 1'b1));
        add_byte(8'hFF, 1'b1, 1'b1, mk_res(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
        add_byte(8'h00, 1'b1, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
        // empty tag: bare "<" opens, "</" closes
        add_cfg('0, '0);
        add_text("<></>z", 1'b1);
        // match on the final byte: region left open, nothing to flush
        add_byte(CH_LT, 1'b1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        // stream ends inside the end tag: still balanced
        add_text("<><", 1'b0);
        add_byte(CH_SLASH, 1'b1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        // mixed case tag, stream ends in the body
        add_cfg(64'h6241, 4'd2);
        add_text("<aB>k", 1'b1);
        // tag changes while bytes wait in the window
        add_text("<a", 1'b0);
        add_cfg('0, '0);
        add_text("c", 1'b1);
        // oversize length with all-ones tag: clamped to eight characters
        add_cfg('1, 4'd15);
        add_byte(CH_LT, 1'b0, 1'b0, '0);
        for (k = 0; k < 3; k++)
            add_byte(8'hFF, 1'b0, 1'b0, '0);
        add_byte("a", 1'b1, 1'b0, '0);

        for (i = 0; i < stim_rows.size(); i++)
        begin
            if (stim_rows[i].is_cfg)
            begin
                wait_idle();
                load_tag(stim_rows[i].chars, stim_rows[i].len);
            end
            else
                send_item(stim_rows[i].b, stim_rows[i].last, stim_rows[i].typed,
                          stim_rows[i].want);
        end

        // random phases, each with its own tag setting
        rand_cnt = 0;
        phase    = 0;
        while (rand_cnt < RANDOM_ITEMS)
        begin
            wait_idle();
            sel = $urandom_range(0, 9);
            len = (sel < 2) ? TLEN_W'($urandom_range(6, 15)) : TLEN_W'($urandom_range(0, 5));
            for (k = 0; k < 8; k++)
                chars[8*k +: 8] = letter_byte();
            if (sel == 9)
                chars = {$urandom, $urandom};
            load_tag(chars, len);
            if (phase == 1)
                hold_req = 1'b1;
            build_stream($urandom_range(12, 40), $urandom_range(0, 4) != 0);
            for (k = 0; k < stream_q.size(); k++)
                send_item(stream_q[k].b, stream_q[k].last, 1'b0, '0);
            rand_cnt += stream_q.size();
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (kept_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
